// ===== rtl/cpsc_pkg.sv =====
package cpsc_pkg;

    // field widths
    localparam int SPEED_W  = 17;
    localparam int ERR_W    = 18;
    localparam int DERR_W   = 19;
    localparam int GAIN_W   = 16;
    localparam int E_W      = 16;
    localparam int DE_W     = 17;
    localparam int DDE_W    = 18;
    localparam int LIM15_W  = 20;
    localparam int PROD_W   = GAIN_W + 1 + DERR_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int Q_SHIFT  = 12;
    localparam int QUOT_W   = ACC_W - Q_SHIFT;
    localparam int SUM_W    = QUOT_W + 1;
    localparam int DRV_W    = 16;
    localparam int OUT_W    = 15;

    // output saturation and clamp scaling
    localparam int OUTPUT_LIMIT = 15000;
    localparam int CLAMP_SHIFT  = 4;

    // configuration port
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int BAND_W  = 48;
    localparam int OUTER_W = 32;
    localparam int NBANDS  = 4;

    localparam logic [BAND_W-1:0]  BAND0_RST  = 48'd8796213808742;
    localparam logic [BAND_W-1:0]  BAND1_RST  = 48'd22870781400269;
    localparam logic [BAND_W-1:0]  BAND2_RST  = 48'd38702003985203;
    localparam logic [BAND_W-1:0]  BAND3_RST  = 48'd0;
    localparam logic [OUTER_W-1:0] OUTER_RST  = 32'd93983744;
    localparam logic [BAND_W-1:0]  THRESH_RST = 48'd128850329610000;

    typedef enum logic [2:0] {
        REG_BAND0  = 3'd0,
        REG_BAND1  = 3'd1,
        REG_BAND2  = 3'd2,
        REG_BAND3  = 3'd3,
        REG_OUTER  = 3'd4,
        REG_THRESH = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [NBANDS-1:0][BAND_W-1:0] band_gains;
        logic [OUTER_W-1:0]            outer_gains;
        logic [BAND_W-1:0]             thresholds;
    } cfg_t;

    // microcode fields
    typedef enum logic [0:0] {
        SEQ_NEXT,
        SEQ_EMIT
    } seq_op_t;

    typedef enum logic [2:0] {
        MA_OKP,
        MA_OKD,
        MA_KP,
        MA_KI,
        MA_KD
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_ERR,
        MB_DERR,
        MB_E,
        MB_DE,
        MB_DDE
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_SETUP,
        DP_OUTER,
        DP_DIFF,
        DP_DELTA,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        seq_op_t seq_op;
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        acc_op_t acc_op;
        dp_op_t  dp_op;
    } ctrl_t;

    localparam int STEP_W    = 4;
    localparam int LAST_STEP = 10;

    localparam ctrl_t CTRL_NOP = '{SEQ_NEXT, MA_OKP, MB_ERR, ACC_HOLD, DP_NONE};

    // control store: outer pd, then inner pid, then clamp and commit
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = CTRL_NOP;
        case (step)
            4'd0:  c = '{SEQ_NEXT, MA_OKP, MB_ERR,  ACC_HOLD, DP_SETUP};
            4'd1:  c = '{SEQ_NEXT, MA_OKP, MB_ERR,  ACC_HOLD, DP_NONE};
            4'd2:  c = '{SEQ_NEXT, MA_OKD, MB_DERR, ACC_LOAD, DP_NONE};
            4'd3:  c = '{SEQ_NEXT, MA_OKD, MB_DERR, ACC_ADD,  DP_NONE};
            4'd4:  c = '{SEQ_NEXT, MA_OKP, MB_ERR,  ACC_HOLD, DP_OUTER};
            4'd5:  c = '{SEQ_NEXT, MA_KI,  MB_E,    ACC_HOLD, DP_DIFF};
            4'd6:  c = '{SEQ_NEXT, MA_KP,  MB_DE,   ACC_LOAD, DP_NONE};
            4'd7:  c = '{SEQ_NEXT, MA_KD,  MB_DDE,  ACC_ADD,  DP_NONE};
            4'd8:  c = '{SEQ_NEXT, MA_KD,  MB_DDE,  ACC_ADD,  DP_NONE};
            4'd9:  c = '{SEQ_NEXT, MA_KD,  MB_DDE,  ACC_HOLD, DP_DELTA};
            4'd10: c = '{SEQ_EMIT, MA_KD,  MB_DDE,  ACC_HOLD, DP_FINISH};
            default: c = CTRL_NOP;
        endcase
        return c;
    endfunction

    // divide by 4096 rounding toward zero
    function automatic logic signed [QUOT_W-1:0] trunc_q12(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] biased;
        biased = x + (x[ACC_W-1] ? ACC_W'((1 << Q_SHIFT) - 1) : '0);
        return biased[ACC_W-1:Q_SHIFT];
    endfunction

endpackage

// ===== rtl/cascaded_pid_speed_controller.sv =====
// channel   | handshake                   | payload
// ----------+-----------------------------+---------------------------------------
// input     | s_valid / s_ready           | s_measured_speed, s_target_speed
// result    | m_valid / m_ready           | m_drive_value
// config    | psel, penable, pwrite       | paddr, pwdata, prdata (pready tied high)
//
// one item runs through the microcode steps of the sequencer after acceptance (one control word
// per step sharing a single 17x19 multiplier), then returns to idle before accepting the next item
// the result sits in an output register; the next item is accepted while it waits
// the last step holds when the output register is still full and m_ready is low
// synchronous active-low reset clears controller state and restores register defaults
module cascaded_pid_speed_controller (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [cpsc_pkg::PADDR_W-1:0]          paddr,
    input  logic [cpsc_pkg::PDATA_W-1:0]          pwdata,
    output logic [cpsc_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [cpsc_pkg::SPEED_W-1:0]   s_measured_speed,
    input  logic signed [cpsc_pkg::SPEED_W-1:0]   s_target_speed,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cpsc_pkg::OUT_W-1:0]     m_drive_value
);

    cpsc_pkg::cfg_t                      cfg;
    cpsc_pkg::ctrl_t                     ctrl;
    logic                                busy, done, start, out_full;
    logic signed [cpsc_pkg::OUT_W-1:0]   result;
    logic                                m_valid_reg;
    logic signed [cpsc_pkg::OUT_W-1:0]   m_drive_value_reg;

    assign pready   = 1'b1;
    assign s_ready  = !busy;
    assign start    = s_valid && s_ready;
    assign out_full = m_valid_reg && !m_ready;

    cpsc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    cpsc_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_full (out_full),
        .ctrl     (ctrl),
        .busy     (busy),
        .done     (done)
    );

    cpsc_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (start),
        .measured_speed (s_measured_speed),
        .target_speed   (s_target_speed),
        .cfg            (cfg),
        .ctrl           (ctrl),
        .result         (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_drive_value_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_value = m_drive_value_reg;

    // an accepted item keeps the input closed on the next cycle
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("input reopened right after accepting an item");

endmodule

// ===== rtl/cpsc_regs.sv =====
module cpsc_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cpsc_pkg::PADDR_W-1:0]       paddr,
    input  logic [cpsc_pkg::PDATA_W-1:0]       pwdata,
    output logic [cpsc_pkg::PDATA_W-1:0]       prdata,
    output cpsc_pkg::cfg_t                     cfg
);

    logic [cpsc_pkg::BAND_W-1:0]  band0_reg, band1_reg, band2_reg, band3_reg;
    logic [cpsc_pkg::OUTER_W-1:0] outer_reg;
    logic [cpsc_pkg::BAND_W-1:0]  thresh_reg;
    logic [2:0]                   idx;
    logic                         wr_en;

    assign idx   = paddr[cpsc_pkg::PADDR_W-1:3];
    assign wr_en = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band0_reg  <= cpsc_pkg::BAND0_RST;
            band1_reg  <= cpsc_pkg::BAND1_RST;
            band2_reg  <= cpsc_pkg::BAND2_RST;
            band3_reg  <= cpsc_pkg::BAND3_RST;
            outer_reg  <= cpsc_pkg::OUTER_RST;
            thresh_reg <= cpsc_pkg::THRESH_RST;
        end else if (wr_en) begin
            case (idx)
                cpsc_pkg::REG_BAND0:  band0_reg  <= pwdata[cpsc_pkg::BAND_W-1:0];
                cpsc_pkg::REG_BAND1:  band1_reg  <= pwdata[cpsc_pkg::BAND_W-1:0];
                cpsc_pkg::REG_BAND2:  band2_reg  <= pwdata[cpsc_pkg::BAND_W-1:0];
                cpsc_pkg::REG_BAND3:  band3_reg  <= pwdata[cpsc_pkg::BAND_W-1:0];
                cpsc_pkg::REG_OUTER:  outer_reg  <= pwdata[cpsc_pkg::OUTER_W-1:0];
                cpsc_pkg::REG_THRESH: thresh_reg <= pwdata[cpsc_pkg::BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux, unmapped addresses read zero
    always_comb begin
        case (idx)
            cpsc_pkg::REG_BAND0:  prdata = cpsc_pkg::PDATA_W'(band0_reg);
            cpsc_pkg::REG_BAND1:  prdata = cpsc_pkg::PDATA_W'(band1_reg);
            cpsc_pkg::REG_BAND2:  prdata = cpsc_pkg::PDATA_W'(band2_reg);
            cpsc_pkg::REG_BAND3:  prdata = cpsc_pkg::PDATA_W'(band3_reg);
            cpsc_pkg::REG_OUTER:  prdata = cpsc_pkg::PDATA_W'(outer_reg);
            cpsc_pkg::REG_THRESH: prdata = cpsc_pkg::PDATA_W'(thresh_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.band_gains[0] = band0_reg;
    assign cfg.band_gains[1] = band1_reg;
    assign cfg.band_gains[2] = band2_reg;
    assign cfg.band_gains[3] = band3_reg;
    assign cfg.outer_gains   = outer_reg;
    assign cfg.thresholds    = thresh_reg;

endmodule

// ===== rtl/cpsc_sequencer.sv =====
module cpsc_sequencer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic            out_full,
    output cpsc_pkg::ctrl_t ctrl,
    output logic            busy,
    output logic            done
);

    logic [cpsc_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        busy_reg, busy_next;
    cpsc_pkg::ctrl_t             word;
    logic                        stall;

    assign word  = cpsc_pkg::ucode(step_reg);
    assign stall = (word.seq_op == cpsc_pkg::SEQ_EMIT) && out_full;

    // step counter and control word issue
    always_comb begin
        step_next = step_reg;
        busy_next = busy_reg;
        ctrl      = cpsc_pkg::CTRL_NOP;
        done      = 1'b0;
        if (busy_reg) begin
            ctrl = word;
            case (word.seq_op)
                cpsc_pkg::SEQ_NEXT: begin
                    step_next = step_reg + 1'b1;
                end
                cpsc_pkg::SEQ_EMIT: begin
                    if (stall) begin
                        // wait on self until the output register frees up
                        ctrl.dp_op  = cpsc_pkg::DP_NONE;
                        ctrl.acc_op = cpsc_pkg::ACC_HOLD;
                    end else begin
                        done      = 1'b1;
                        busy_next = 1'b0;
                        step_next = '0;
                    end
                end
                default: ;
            endcase
        end else if (start) begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

    // an item finishes only from the emit step
    a_end_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> $past(step_reg) == cpsc_pkg::STEP_W'(cpsc_pkg::LAST_STEP))
        else $error("sequencer left busy before the last step");

    // a result is never issued into a full output register
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !out_full)
        else $error("result issued while output register full");

endmodule

// ===== rtl/cpsc_datapath.sv =====
module cpsc_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   load,
    input  logic signed [cpsc_pkg::SPEED_W-1:0]    measured_speed,
    input  logic signed [cpsc_pkg::SPEED_W-1:0]    target_speed,
    input  cpsc_pkg::cfg_t                         cfg,
    input  cpsc_pkg::ctrl_t                        ctrl,
    output logic signed [cpsc_pkg::OUT_W-1:0]      result
);

    localparam int SW = cpsc_pkg::SUM_W;
    localparam logic signed [SW-1:0] LIM_POS = SW'(cpsc_pkg::OUTPUT_LIMIT);
    localparam logic signed [SW-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [cpsc_pkg::QUOT_W-1:0] E_MAX = cpsc_pkg::QUOT_W'(32767);
    localparam logic signed [cpsc_pkg::QUOT_W-1:0] E_MIN = -cpsc_pkg::QUOT_W'(32768);

    // item operands
    logic signed [cpsc_pkg::SPEED_W-1:0] meas_reg, targ_reg;
    logic signed [cpsc_pkg::ERR_W-1:0]   err_reg;
    logic signed [cpsc_pkg::DERR_W-1:0]  derr_reg;
    logic [cpsc_pkg::GAIN_W-1:0]         kp_reg, ki_reg, kd_reg;
    logic signed [cpsc_pkg::E_W-1:0]     e_reg;
    logic signed [cpsc_pkg::DE_W-1:0]    de_reg;
    logic signed [cpsc_pkg::DDE_W-1:0]   dde_reg;
    logic signed [cpsc_pkg::LIM15_W-1:0] lim15_reg;
    logic signed [SW-1:0]                sum_reg;
    logic signed [cpsc_pkg::PROD_W-1:0]  prod_reg;
    logic signed [cpsc_pkg::ACC_W-1:0]   acc_reg;

    // controller state
    logic signed [cpsc_pkg::ERR_W-1:0]   prev_outer_reg;
    logic signed [cpsc_pkg::E_W-1:0]     e1_reg, e2_reg;
    logic signed [cpsc_pkg::DRV_W-1:0]   drive_reg, drive_next;

    // setup logic
    logic signed [cpsc_pkg::ERR_W-1:0]   err_c;
    logic [cpsc_pkg::SPEED_W-1:0]        mag_c;
    logic [cpsc_pkg::BAND_W-1:0]         gains_c;

    // multiplier operands
    logic [cpsc_pkg::GAIN_W-1:0]         op_a;
    logic signed [cpsc_pkg::DERR_W-1:0]  op_b;

    // scaled results
    logic signed [cpsc_pkg::QUOT_W-1:0]  quot_c;
    logic signed [SW-1:0]                lim15_ext, clamp_c;

    assign err_c = cpsc_pkg::ERR_W'(targ_reg) - cpsc_pkg::ERR_W'(meas_reg);
    assign mag_c = meas_reg[cpsc_pkg::SPEED_W-1] ? cpsc_pkg::SPEED_W'(-meas_reg)
                                                 : cpsc_pkg::SPEED_W'(meas_reg);

    // gain band select by speed magnitude, first match wins
    always_comb begin
        if (mag_c < cpsc_pkg::SPEED_W'(cfg.thresholds[15:0]))
            gains_c = cfg.band_gains[0];
        else if (mag_c < cpsc_pkg::SPEED_W'(cfg.thresholds[31:16]))
            gains_c = cfg.band_gains[1];
        else if (mag_c < cpsc_pkg::SPEED_W'(cfg.thresholds[47:32]))
            gains_c = cfg.band_gains[2];
        else
            gains_c = cfg.band_gains[3];
    end

    // operand muxes for the shared multiplier
    always_comb begin
        case (ctrl.mul_a)
            cpsc_pkg::MA_OKP: op_a = cfg.outer_gains[15:0];
            cpsc_pkg::MA_OKD: op_a = cfg.outer_gains[31:16];
            cpsc_pkg::MA_KP:  op_a = kp_reg;
            cpsc_pkg::MA_KI:  op_a = ki_reg;
            cpsc_pkg::MA_KD:  op_a = kd_reg;
            default:          op_a = '0;
        endcase
        case (ctrl.mul_b)
            cpsc_pkg::MB_ERR:  op_b = cpsc_pkg::DERR_W'(err_reg);
            cpsc_pkg::MB_DERR: op_b = derr_reg;
            cpsc_pkg::MB_E:    op_b = cpsc_pkg::DERR_W'(e_reg);
            cpsc_pkg::MB_DE:   op_b = cpsc_pkg::DERR_W'(de_reg);
            cpsc_pkg::MB_DDE:  op_b = cpsc_pkg::DERR_W'(dde_reg);
            default:           op_b = '0;
        endcase
    end

    assign quot_c = cpsc_pkg::trunc_q12(acc_reg);

    // clamp toward 15*e on the error's side, then saturate
    assign lim15_ext = SW'(lim15_reg);
    always_comb begin
        if ((!e_reg[cpsc_pkg::E_W-1] && sum_reg >= lim15_ext) ||
            (e_reg[cpsc_pkg::E_W-1] && sum_reg <= lim15_ext))
            clamp_c = lim15_ext;
        else
            clamp_c = sum_reg;
        if (clamp_c > LIM_POS)
            drive_next = cpsc_pkg::DRV_W'(LIM_POS);
        else if (clamp_c < LIM_NEG)
            drive_next = cpsc_pkg::DRV_W'(LIM_NEG);
        else
            drive_next = cpsc_pkg::DRV_W'(clamp_c);
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (load) begin
            meas_reg <= measured_speed;
            targ_reg <= target_speed;
        end
    end

    // multiplier and accumulator
    always_ff @(posedge aclk) begin
        prod_reg <= $signed({1'b0, op_a}) * op_b;
        case (ctrl.acc_op)
            cpsc_pkg::ACC_LOAD: acc_reg <= cpsc_pkg::ACC_W'(prod_reg);
            cpsc_pkg::ACC_ADD:  acc_reg <= acc_reg + cpsc_pkg::ACC_W'(prod_reg);
            default: ;
        endcase
    end

    // working registers per datapath op
    always_ff @(posedge aclk) begin
        case (ctrl.dp_op)
            cpsc_pkg::DP_SETUP: begin
                err_reg  <= err_c;
                derr_reg <= cpsc_pkg::DERR_W'(err_c) - cpsc_pkg::DERR_W'(prev_outer_reg);
                kp_reg   <= gains_c[15:0];
                ki_reg   <= gains_c[31:16];
                kd_reg   <= gains_c[47:32];
            end
            cpsc_pkg::DP_OUTER: begin
                if (quot_c > E_MAX)
                    e_reg <= cpsc_pkg::E_W'(E_MAX);
                else if (quot_c < E_MIN)
                    e_reg <= cpsc_pkg::E_W'(E_MIN);
                else
                    e_reg <= cpsc_pkg::E_W'(quot_c);
            end
            cpsc_pkg::DP_DIFF: begin
                de_reg    <= cpsc_pkg::DE_W'(e_reg) - cpsc_pkg::DE_W'(e1_reg);
                dde_reg   <= cpsc_pkg::DDE_W'(e_reg) - (cpsc_pkg::DDE_W'(e1_reg) <<< 1)
                             + cpsc_pkg::DDE_W'(e2_reg);
                lim15_reg <= (cpsc_pkg::LIM15_W'(e_reg) <<< cpsc_pkg::CLAMP_SHIFT)
                             - cpsc_pkg::LIM15_W'(e_reg);
            end
            cpsc_pkg::DP_DELTA: begin
                sum_reg <= SW'(drive_reg) + SW'(quot_c);
            end
            default: ;
        endcase
    end

    // controller state commits once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_outer_reg <= '0;
            e1_reg         <= '0;
            e2_reg         <= '0;
            drive_reg      <= '0;
        end else if (ctrl.dp_op == cpsc_pkg::DP_FINISH) begin
            prev_outer_reg <= err_reg;
            e1_reg         <= e_reg;
            e2_reg         <= e1_reg;
            drive_reg      <= drive_next;
        end
    end

    assign result = drive_next[cpsc_pkg::OUT_W-1:0];

    // the stored drive always stays inside the output limit
    a_drive_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (drive_reg <= cpsc_pkg::DRV_W'(cpsc_pkg::OUTPUT_LIMIT)) &&
        (drive_reg >= -cpsc_pkg::DRV_W'(cpsc_pkg::OUTPUT_LIMIT)))
        else $error("drive accumulator outside output limit");

endmodule
